// File: rtl/dnsar_pkg.sv
package dnsar_pkg;

  // Default sizing
  localparam int NAME_BYTES_DEF = 64;
  localparam int ENTRIES_DEF    = 16;
  localparam int MAX_PACKET_DEF = 1024;

  // Item codes on the request channel
  localparam logic [1:0] REQ_PKT_BYTE  = 2'd0;
  localparam logic [1:0] REQ_TBL_BYTE  = 2'd1;
  localparam logic [1:0] REQ_TBL_VALID = 2'd2;

  // Parse phases
  localparam logic [2:0] PH_HEADER    = 3'd0;
  localparam logic [2:0] PH_LEN       = 3'd1;
  localparam logic [2:0] PH_LABEL     = 3'd2;
  localparam logic [2:0] PH_TYPECLASS = 3'd3;
  localparam logic [2:0] PH_DONE      = 3'd4;

  // DNS wire constants
  localparam int          HDR_LEN        = 12;
  localparam int          LABEL_MAX      = 63;
  localparam logic [7:0]  FLAGS_HI       = 8'h81;
  localparam logic [7:0]  RCODE_OK       = 8'd0;
  localparam logic [7:0]  RCODE_NXDOMAIN = 8'd3;
  localparam logic [15:0] NAME_PTR       = 16'hC00C;
  localparam logic [7:0]  RDATA_LEN      = 8'd4;

endpackage

// File: rtl/dnsar_ifs.sv
interface dnsar_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] data_byte;
  logic       packet_end;
  logic [3:0] entry_index;
  logic [6:0] entry_offset;

  modport source (output valid, req_type, data_byte, packet_end, entry_index,
                  entry_offset, input ready);
  modport sink   (input valid, req_type, data_byte, packet_end, entry_index,
                  entry_offset, output ready);
endinterface

interface dnsar_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] response_word;
  logic [3:0]  byte_count;
  logic        last_word;
  logic        status;

  modport source (output valid, response_word, byte_count, last_word, status,
                  input ready);
  modport sink   (input valid, response_word, byte_count, last_word, status,
                  output ready);
endinterface

// File: rtl/dns_a_record_responder_core.sv
// DNS A-record responder core.
// in_ch carries one beat per item: a request packet byte (packet_end on the
// final byte), a table name/address byte write, or an entry valid-bit write.
// Packet and table beats are taken one per cycle while the block is parsing.
// After the final packet byte the block leaves the input stalled while it
// looks up the question name and streams the response on out_ch as 8-byte
// beats, first byte in bits 63..56, last_word on the final beat.
// Lookup walks the entries in order through the name memories, with a read
// state and a check state per compared name byte and the read state alone
// per skipped entry; emission builds each word through the same memory read
// ports, with a read state and a check state per response byte and an output
// state per word. A malformed request yields one beat with status set.
// The output register lets a word wait while the next one is assembled;
// when out_ch stalls, the block holds the word and pauses assembly.
// Reset (synchronous, active low) clears the parse state, the entry valid
// bits and the output register; name and address memories are not cleared,
// and no clearing pass runs: the block takes items right after reset.
module dns_a_record_responder_core
  import dnsar_pkg::*;
#(
  parameter int NAME_BYTES = NAME_BYTES_DEF,
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int MAX_PACKET = MAX_PACKET_DEF
) (
  input  logic clk,
  input  logic rst_n,
  dnsar_req_if.sink   in_ch,
  dnsar_rsp_if.source out_ch
);

  localparam int NLW      = $clog2(NAME_BYTES + 1);
  localparam int QAW      = $clog2(NAME_BYTES);
  localparam int EW       = $clog2(ENTRIES + 1);
  localparam int EIW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TNW      = $clog2(ENTRIES * NAME_BYTES);
  localparam int TAW      = $clog2(ENTRIES * 4);
  localparam int PW       = $clog2(MAX_PACKET);
  localparam int RESP_MAX = HDR_LEN + NAME_BYTES + 20;
  localparam int JW       = $clog2(RESP_MAX + 1);

  // Sequencer states
  localparam logic [2:0] S_PARSE   = 3'd0;
  localparam logic [2:0] S_CMP_RD  = 3'd1;
  localparam logic [2:0] S_CMP_CHK = 3'd2;
  localparam logic [2:0] S_EM_RD   = 3'd3;
  localparam logic [2:0] S_EM_CHK  = 3'd4;
  localparam logic [2:0] S_EM_OUT  = 3'd5;
  localparam logic [2:0] S_MAL     = 3'd6;

  // Memories
  logic [7:0] qname_mem [NAME_BYTES];
  logic [7:0] tname_mem [ENTRIES * NAME_BYTES];
  logic [7:0] taddr_mem [ENTRIES * 4];

  logic [2:0]      state_r, state_nxt;
  logic [PW-1:0]   pos_r, pos_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [15:0]     id_r, id_nxt;
  logic [15:0]     qtot_r, qtot_nxt;
  logic [NLW-1:0]  nl_r, nl_nxt;
  logic [5:0]      lrem_r, lrem_nxt;
  logic [15:0]     qtype_r, qtype_nxt;
  logic [15:0]     qclass_r, qclass_nxt;
  logic            mal_r, mal_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic [EW-1:0]   e_r, e_nxt;
  logic [NLW-1:0]  i_r, i_nxt;
  logic            hit_r, hit_nxt;
  logic [EIW-1:0]  hit_e_r, hit_e_nxt;
  logic [JW-1:0]   j_r, j_nxt;
  logic [JW-1:0]   n_r, n_nxt;
  logic [63:0]     word_r, word_nxt;
  logic [3:0]      cnt_r, cnt_nxt;
  logic            wlast_r, wlast_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [63:0]     out_word_r, out_word_nxt;
  logic [3:0]      out_cnt_r, out_cnt_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_status_r, out_status_nxt;

  logic            qn_we;
  logic [QAW-1:0]  qn_wa, qn_ra;
  logic [7:0]      qn_rd_r;
  logic            tn_we, ta_we;
  logic [TNW-1:0]  tn_wa, tn_ra;
  logic [TAW-1:0]  ta_wa, ta_ra;
  logic [7:0]      tn_rd_r, ta_rd_r;

  logic            accept;
  logic            out_free;
  logic [EIW-1:0]  e_idx;
  logic [JW-1:0]   k_off;
  logic [7:0]      emit_byte;
  logic [7:0]      b;

  assign in_ch.ready = (state_r == S_PARSE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign b           = in_ch.data_byte;
  assign e_idx       = e_r[EIW-1:0];
  assign k_off       = j_r - JW'(HDR_LEN) - JW'(nl_r);

  assign out_ch.valid         = out_valid_r;
  assign out_ch.response_word = out_word_r;
  assign out_ch.byte_count    = out_cnt_r;
  assign out_ch.last_word     = out_last_r;
  assign out_ch.status        = out_status_r;

  // Table load decode
  always_comb begin
    tn_we = 1'b0;
    ta_we = 1'b0;
    tn_wa = TNW'(in_ch.entry_index) * TNW'(NAME_BYTES) + TNW'(in_ch.entry_offset);
    ta_wa = TAW'(in_ch.entry_index) * TAW'(4)
            + TAW'(32'(in_ch.entry_offset) - NAME_BYTES);
    if (accept && in_ch.req_type == REQ_TBL_BYTE && 32'(in_ch.entry_index) < ENTRIES)
    begin
      if (32'(in_ch.entry_offset) < NAME_BYTES) begin
        tn_we = 1'b1;
      end else if (32'(in_ch.entry_offset) < NAME_BYTES + 4) begin
        ta_we = 1'b1;
      end
    end
  end

  // Read addresses follow the sequencer
  always_comb begin
    qn_ra = i_r[QAW-1:0];
    tn_ra = TNW'(e_idx) * TNW'(NAME_BYTES) + TNW'(i_r);
    ta_ra = TAW'({hit_e_r, k_off[1:0]});
    if (state_r == S_EM_RD) begin
      qn_ra = QAW'(j_r - JW'(HDR_LEN));
    end
  end

  always_ff @(posedge clk) begin
    if (qn_we) begin
      qname_mem[qn_wa] <= b;
    end
    qn_rd_r <= qname_mem[qn_ra];
  end

  always_ff @(posedge clk) begin
    if (tn_we) begin
      tname_mem[tn_wa] <= b;
    end
    tn_rd_r <= tname_mem[tn_ra];
  end

  always_ff @(posedge clk) begin
    if (ta_we) begin
      taddr_mem[ta_wa] <= b;
    end
    ta_rd_r <= taddr_mem[ta_ra];
  end

  // Response byte at position j_r
  always_comb begin
    emit_byte = 8'h00;
    if (32'(j_r) < HDR_LEN) begin
      case (j_r[3:0])
        4'd0:    emit_byte = id_r[15:8];
        4'd1:    emit_byte = id_r[7:0];
        4'd2:    emit_byte = FLAGS_HI;
        4'd3:    emit_byte = hit_r ? RCODE_OK : RCODE_NXDOMAIN;
        4'd4:    emit_byte = qtot_r[15:8];
        4'd5:    emit_byte = qtot_r[7:0];
        4'd7:    emit_byte = {7'd0, hit_r};
        default: emit_byte = 8'h00;
      endcase
    end else if (32'(j_r) < HDR_LEN + 32'(nl_r)) begin
      emit_byte = qn_rd_r;
    end else begin
      case (k_off[4:0])
        5'd0:    emit_byte = qtype_r[15:8];
        5'd1:    emit_byte = qtype_r[7:0];
        5'd2:    emit_byte = qclass_r[15:8];
        5'd3:    emit_byte = qclass_r[7:0];
        5'd4:    emit_byte = NAME_PTR[15:8];
        5'd5:    emit_byte = NAME_PTR[7:0];
        5'd6:    emit_byte = qtype_r[15:8];
        5'd7:    emit_byte = qtype_r[7:0];
        5'd8:    emit_byte = qclass_r[15:8];
        5'd9:    emit_byte = qclass_r[7:0];
        5'd15:   emit_byte = RDATA_LEN;
        5'd16, 5'd17, 5'd18, 5'd19: emit_byte = ta_rd_r;
        default: emit_byte = 8'h00;
      endcase
    end
  end

  // Parser, lookup and emission sequencer
  always_comb begin
    state_nxt  = state_r;
    pos_nxt    = pos_r;
    phase_nxt  = phase_r;
    id_nxt     = id_r;
    qtot_nxt   = qtot_r;
    nl_nxt     = nl_r;
    lrem_nxt   = lrem_r;
    qtype_nxt  = qtype_r;
    qclass_nxt = qclass_r;
    mal_nxt    = mal_r;
    valid_nxt  = valid_r;
    e_nxt      = e_r;
    i_nxt      = i_r;
    hit_nxt    = hit_r;
    hit_e_nxt  = hit_e_r;
    j_nxt      = j_r;
    n_nxt      = n_r;
    word_nxt   = word_r;
    cnt_nxt    = cnt_r;
    wlast_nxt  = wlast_r;
    qn_we      = 1'b0;
    qn_wa      = nl_r[QAW-1:0];

    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_word_nxt   = out_word_r;
    out_cnt_nxt    = out_cnt_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;

    case (state_r)
      S_PARSE: begin
        if (accept && in_ch.req_type == REQ_TBL_VALID
            && 32'(in_ch.entry_index) < ENTRIES) begin
          valid_nxt[EIW'(in_ch.entry_index)] = b[0];
        end
        if (accept && in_ch.req_type == REQ_PKT_BYTE) begin
          if (32'(pos_r) < MAX_PACKET - 1) begin
            pos_nxt = pos_r + PW'(1);
          end
          if (!mal_r) begin
            case (phase_r)
              PH_HEADER: begin
                if (32'(pos_r) == 0) id_nxt[15:8] = b;
                if (32'(pos_r) == 1) id_nxt[7:0] = b;
                if (32'(pos_r) == 4) qtot_nxt[15:8] = b;
                if (32'(pos_r) == 5) qtot_nxt[7:0] = b;
                if (32'(pos_r) >= HDR_LEN - 1) phase_nxt = PH_LEN;
              end
              PH_LEN: begin
                if (32'(b) > LABEL_MAX || 32'(nl_r) >= NAME_BYTES) begin
                  mal_nxt = 1'b1;
                end else begin
                  qn_we  = 1'b1;
                  nl_nxt = nl_r + NLW'(1);
                  lrem_nxt = b[5:0];
                  phase_nxt = (b == 8'd0) ? PH_TYPECLASS : PH_LABEL;
                end
              end
              PH_LABEL: begin
                if (32'(nl_r) >= NAME_BYTES) begin
                  mal_nxt = 1'b1;
                end else begin
                  qn_we    = 1'b1;
                  nl_nxt   = nl_r + NLW'(1);
                  lrem_nxt = lrem_r - 6'd1;
                  if (lrem_r == 6'd1) phase_nxt = PH_LEN;
                end
              end
              PH_TYPECLASS: begin
                case (lrem_r[1:0])
                  2'd0:    qtype_nxt[15:8]  = b;
                  2'd1:    qtype_nxt[7:0]   = b;
                  2'd2:    qclass_nxt[15:8] = b;
                  default: qclass_nxt[7:0]  = b;
                endcase
                lrem_nxt = lrem_r + 6'd1;
                if (lrem_r == 6'd3) begin
                  lrem_nxt  = 6'd0;
                  phase_nxt = PH_DONE;
                end
              end
              default: ;
            endcase
          end
          if (in_ch.packet_end) begin
            // Route by the state this byte leaves behind
            if (mal_nxt || phase_nxt != PH_DONE) begin
              state_nxt = S_MAL;
            end else begin
              state_nxt = S_CMP_RD;
              e_nxt     = '0;
              i_nxt     = '0;
            end
          end
        end
      end

      S_CMP_RD: begin
        if (32'(e_r) >= ENTRIES) begin
          hit_nxt   = 1'b0;
          state_nxt = S_EM_RD;
        end else if (!valid_r[e_idx]) begin
          e_nxt = e_r + EW'(1);
        end else if (i_r == nl_r) begin
          hit_nxt   = 1'b1;
          hit_e_nxt = e_idx;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_CMP_CHK;
        end
        if (state_nxt == S_EM_RD) begin
          j_nxt    = '0;
          n_nxt    = JW'(HDR_LEN + 4) + JW'(nl_r) + (hit_nxt ? JW'(16) : JW'(0));
          word_nxt = '0;
          cnt_nxt  = '0;
        end
      end

      S_CMP_CHK: begin
        state_nxt = S_CMP_RD;
        if (qn_rd_r == tn_rd_r) begin
          i_nxt = i_r + NLW'(1);
        end else begin
          i_nxt = '0;
          e_nxt = e_r + EW'(1);
        end
      end

      S_EM_RD: begin
        state_nxt = S_EM_CHK;
      end

      S_EM_CHK: begin
        word_nxt  = word_r | ({56'd0, emit_byte} << (6'd56 - {cnt_r[2:0], 3'd0}));
        cnt_nxt   = cnt_r + 4'd1;
        wlast_nxt = (j_r == n_r - JW'(1));
        if (cnt_r == 4'd7 || wlast_nxt) begin
          state_nxt = S_EM_OUT;
        end else begin
          j_nxt     = j_r + JW'(1);
          state_nxt = S_EM_RD;
        end
      end

      S_EM_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = word_r;
          out_cnt_nxt    = cnt_r;
          out_last_nxt   = wlast_r;
          out_status_nxt = 1'b0;
          word_nxt       = '0;
          cnt_nxt        = '0;
          j_nxt          = j_r + JW'(1);
          state_nxt      = wlast_r ? S_PARSE : S_EM_RD;
        end
      end

      S_MAL: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_word_nxt   = '0;
          out_cnt_nxt    = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = 1'b1;
          state_nxt      = S_PARSE;
        end
      end

      default: state_nxt = S_PARSE;
    endcase

    // Drop the parse state on return to parsing
    if (state_r != S_PARSE && state_nxt == S_PARSE) begin
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      nl_nxt    = '0;
      lrem_nxt  = '0;
      mal_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_PARSE;
      pos_r       <= '0;
      phase_r     <= PH_HEADER;
      id_r        <= '0;
      qtot_r      <= '0;
      nl_r        <= '0;
      lrem_r      <= '0;
      qtype_r     <= '0;
      qclass_r    <= '0;
      mal_r       <= 1'b0;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      phase_r     <= phase_nxt;
      id_r        <= id_nxt;
      qtot_r      <= qtot_nxt;
      nl_r        <= nl_nxt;
      lrem_r      <= lrem_nxt;
      qtype_r     <= qtype_nxt;
      qclass_r    <= qclass_nxt;
      mal_r       <= mal_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    i_r          <= i_nxt;
    hit_r        <= hit_nxt;
    hit_e_r      <= hit_e_nxt;
    j_r          <= j_nxt;
    n_r          <= n_nxt;
    word_r       <= word_nxt;
    cnt_r        <= cnt_nxt;
    wlast_r      <= wlast_nxt;
    out_word_r   <= out_word_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

// File: rtl/dnsar_checker.sv
module dnsar_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_word,
  input logic [3:0]  out_count,
  input logic        out_last,
  input logic        out_status
);

  // A stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_word) && $stable(out_count))
    else $error("stalled response beat changed");

  // A dropped request shows as one empty, final beat
  a_mal_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last && out_count == 4'd0 && out_word == 64'd0)
    else $error("malformed status beat not empty and final");

  // Only the final beat of a response is partial
  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_count == 4'd8 && !out_status)
    else $error("non-final response beat not full");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response beat valid after reset");

endmodule

bind dns_a_record_responder_core dnsar_checker u_dnsar_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_word   (out_ch.response_word),
  .out_count  (out_ch.byte_count),
  .out_last   (out_ch.last_word),
  .out_status (out_ch.status)
);

// File: test/tb_dns_a_record_responder_core.sv
`timescale 1ns / 100ps

module tb_dns_a_record_responder_core;
  import dnsar_pkg::*;

  localparam int NAME_BYTES = NAME_BYTES_DEF;
  localparam int ENTRIES    = ENTRIES_DEF;
  localparam int MAX_PACKET = MAX_PACKET_DEF;
  localparam int ENTRY_BYTES = NAME_BYTES + 4;
  // req_type code that the block drops on the floor
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;
  // Input beats to send, and where the full-speed stretch and the long
  // receiver hold-off fall
  localparam int ITEMS     = 460;
  localparam int FAST_FROM = 140;
  localparam int FAST_TO   = 240;
  localparam int HOLD_AT   = 190;

  typedef logic [7:0] bytes_t[$];

  // Scoreboard: a private model of the responder plus the queue of response
  // beats it still owes.
  class dns_scoreboard;
    typedef struct {
      logic [63:0] word;
      logic [3:0]  cnt;
      logic        last;
      logic        status;
    } rsp_beat_t;

    rsp_beat_t   owed_q[$];
    int          errors;
    int          n_hit, n_miss, n_bad, n_beats;

    int          pos;
    logic [2:0]  phase;
    logic [15:0] id_r, qdcount_r, qtype_r, qclass_r;
    logic [7:0]  qname[NAME_BYTES];
    int          nlen, lrem;
    logic        bad;
    logic [7:0]  tname[ENTRIES][NAME_BYTES];
    logic [7:0]  taddr[ENTRIES][4];
    logic        tvalid[ENTRIES];

    function new();
      errors = 0; n_hit = 0; n_miss = 0; n_bad = 0; n_beats = 0;
      id_r = 0; qdcount_r = 0; qtype_r = 0; qclass_r = 0;
      foreach (tvalid[e]) tvalid[e] = 1'b0;
      clear_parse();
    endfunction

    function void clear_parse();
      pos = 0; phase = PH_HEADER; nlen = 0; lrem = 0; bad = 1'b0;
    endfunction

    function void add_name_byte(logic [7:0] b);
      if (nlen >= NAME_BYTES) begin
        bad = 1'b1;
        return;
      end
      qname[nlen] = b;
      nlen++;
    endfunction

    function void parse_byte(logic [7:0] b);
      int p;
      p = pos;
      if (pos < MAX_PACKET - 1) pos++;
      if (bad) return;
      case (phase)
        PH_HEADER: begin
          if (p == 0) id_r[15:8] = b;
          else if (p == 1) id_r[7:0] = b;
          else if (p == 4) qdcount_r[15:8] = b;
          else if (p == 5) qdcount_r[7:0] = b;
          if (p >= HDR_LEN - 1) phase = PH_LEN;
        end
        PH_LEN: begin
          if (b > LABEL_MAX) begin
            bad = 1'b1;
          end else begin
            add_name_byte(b);
            if (!bad) begin
              lrem = b;
              phase = (b == 0) ? PH_TYPECLASS : PH_LABEL;
            end
          end
        end
        PH_LABEL: begin
          add_name_byte(b);
          if (!bad) begin
            lrem--;
            if (lrem == 0) phase = PH_LEN;
          end
        end
        PH_TYPECLASS: begin
          case (lrem)
            0: qtype_r[15:8] = b;
            1: qtype_r[7:0] = b;
            2: qclass_r[15:8] = b;
            default: qclass_r[7:0] = b;
          endcase
          lrem++;
          if (lrem >= 4) begin
            lrem = 0;
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    function void push16(ref bytes_t q, input logic [15:0] v);
      q = {q, v[15:8]};
      q = {q, v[7:0]};
    endfunction

    // Look up the question and queue the response beats.
    function void build_response();
      bytes_t r;
      int hit, words, cnt;
      logic [63:0] w;
      rsp_beat_t bt;
      hit = -1;
      for (int e = 0; e < ENTRIES && hit < 0; e++) begin
        if (tvalid[e]) begin
          hit = e;
          for (int i = 0; i < nlen; i++)
            if (tname[e][i] != qname[i]) hit = -1;
        end
      end
      if (hit >= 0) n_hit++; else n_miss++;
      push16(r, id_r);
      push16(r, {FLAGS_HI, (hit >= 0) ? RCODE_OK : RCODE_NXDOMAIN});
      push16(r, qdcount_r);
      push16(r, (hit >= 0) ? 16'd1 : 16'd0);
      push16(r, 16'd0);
      push16(r, 16'd0);
      for (int i = 0; i < nlen; i++) r = {r, qname[i]};
      push16(r, qtype_r);
      push16(r, qclass_r);
      if (hit >= 0) begin
        push16(r, NAME_PTR);
        push16(r, qtype_r);
        push16(r, qclass_r);
        push16(r, 16'd0);
        push16(r, 16'd0);
        push16(r, {8'd0, RDATA_LEN});
        for (int i = 0; i < 4; i++) r = {r, taddr[hit][i]};
      end
      words = (r.size() + 7) / 8;
      for (int k = 0; k < words; k++) begin
        cnt = r.size() - k * 8;
        if (cnt > 8) cnt = 8;
        w = '0;
        for (int i = 0; i < 8; i++)
          w = {w[55:0], (i < cnt) ? r[k * 8 + i] : 8'h00};
        bt.word = w;
        bt.cnt = cnt[3:0];
        bt.last = (k == words - 1);
        bt.status = 1'b0;
        owed_q = {owed_q, bt};
      end
    endfunction

    function void note_input(logic [1:0] req, logic [7:0] b, logic pe,
                             logic [3:0] idx, logic [6:0] off);
      rsp_beat_t bt;
      if (req == REQ_TBL_BYTE) begin
        if (idx < ENTRIES) begin
          if (off < NAME_BYTES) tname[idx][off] = b;
          else if (off < NAME_BYTES + 4) taddr[idx][off - NAME_BYTES] = b;
        end
        return;
      end
      if (req == REQ_TBL_VALID) begin
        if (idx < ENTRIES) tvalid[idx] = b[0];
        return;
      end
      if (req != REQ_PKT_BYTE) return;
      parse_byte(b);
      if (pe) begin
        if (bad || phase != PH_DONE) begin
          n_bad++;
          bt.word = '0; bt.cnt = '0; bt.last = 1'b1; bt.status = 1'b1;
          owed_q = {owed_q, bt};
        end else begin
          build_response();
        end
        clear_parse();
      end
    endfunction

    task report(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
    endtask

    task check_result(logic [63:0] word, logic [3:0] cnt, logic last, logic status);
      rsp_beat_t bt;
      n_beats++;
      if (owed_q.size() == 0) begin
        report($sformatf("unexpected beat word=%h cnt=%0d", word, cnt));
        return;
      end
      bt = owed_q.pop_front();
      if (word !== bt.word)
        report($sformatf("response_word %h, want %h", word, bt.word));
      if (cnt !== bt.cnt)
        report($sformatf("byte_count %0d, want %0d", cnt, bt.cnt));
      if (last !== bt.last)
        report($sformatf("last_word %b, want %b", last, bt.last));
      if (status !== bt.status)
        report($sformatf("status %b, want %b", status, bt.status));
    endtask
  endclass

  logic clk;
  logic rst_n;
  dnsar_req_if in_if ();
  dnsar_rsp_if out_if ();

  dns_a_record_responder_core i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_if.sink),
    .out_ch(out_if.source)
  );

  dns_scoreboard sb = new();

  // Stimulus bookkeeping: which table bytes have been written, so that a
  // valid bit is only ever raised on an entry whose name and address are in.
  logic [ENTRY_BYTES-1:0] written[ENTRIES];
  bytes_t                 entry_names[ENTRIES];
  bit                     idle_on = 1'b1;
  bit                     hold_req = 1'b0;
  int                     n_sent = 0;
  int                     n_pkts = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Sample both channels; driven values change only after the edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      sb.note_input(in_if.req_type, in_if.data_byte, in_if.packet_end,
                    in_if.entry_index, in_if.entry_offset);
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.response_word, out_if.byte_count,
                      out_if.last_word, out_if.status);
  end

  // Abort if nothing moves on either channel for too long.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= !(idle_on && $urandom_range(99) < 9);
      end
    end
  end

  // Offer one beat and hold it until accepted.
  task send_beat(logic [1:0] req, logic [7:0] b, logic pe, logic [3:0] idx,
                 logic [6:0] off);
    if (n_sent == HOLD_AT) hold_req = 1'b1;
    idle_on = !(n_sent >= FAST_FROM && n_sent < FAST_TO);
    while (idle_on && $urandom_range(99) < 9) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.req_type     <= req;
    in_if.data_byte    <= b;
    in_if.packet_end   <= pe;
    in_if.entry_index  <= idx;
    in_if.entry_offset <= off;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n_sent++;
  endtask

  task write_table(int e, int off, logic [7:0] b);
    send_beat(REQ_TBL_BYTE, b, 1'($urandom_range(1)), 4'(e), 7'(off));
    if (off < ENTRY_BYTES) written[e][off] = 1'b1;
  endtask

  // Load an entry: its name bytes, then its address.
  task load_entry(int e, bytes_t nm);
    for (int i = 0; i < nm.size(); i++)
      write_table(e, i, nm[i]);
    for (int i = 0; i < 4; i++)
      write_table(e, NAME_BYTES + i, 8'($urandom));
    entry_names[e] = nm;
  endtask

  function automatic bit entry_loaded(int e);
    if (entry_names[e].size() == 0) return 1'b0;
    for (int i = 0; i < entry_names[e].size(); i++)
      if (!written[e][i]) return 1'b0;
    for (int i = 0; i < 4; i++)
      if (!written[e][NAME_BYTES + i]) return 1'b0;
    return 1'b1;
  endfunction

  // Send a cleared valid bit instead when the entry is not loaded.
  task set_valid(int e, bit v);
    logic [7:0] b;
    b = 8'($urandom);
    b[0] = v && entry_loaded(e);
    send_beat(REQ_TBL_VALID, b, 1'($urandom_range(1)), 4'(e), 7'($urandom));
  endtask

  function automatic bytes_t make_name(int labels, int max_len);
    bytes_t q;
    int len;
    for (int l = 0; l < labels; l++) begin
      len = $urandom_range(max_len, 1);
      q = {q, 8'(len)};
      for (int i = 0; i < len; i++) q = {q, 8'($urandom)};
    end
    q = {q, 8'h00};
    return q;
  endfunction

  function automatic bytes_t make_packet(bytes_t nm, int trailing);
    bytes_t q;
    for (int i = 0; i < HDR_LEN; i++) q = {q, 8'($urandom)};
    foreach (nm[i]) q = {q, nm[i]};
    if ($urandom_range(1)) begin
      q = {q, 8'h00, 8'h01, 8'h00, 8'h01};
    end else begin
      repeat (4) q = {q, 8'($urandom)};
    end
    repeat (trailing) q = {q, 8'($urandom)};
    return q;
  endfunction

  // Stream a packet; now and then slip a load beat or an ignored beat in.
  // Stray table writes stay clear of the name bytes so that a valid entry
  // keeps a well-formed name.
  task send_packet(bytes_t pkt);
    int e;
    foreach (pkt[i]) begin
      if ($urandom_range(99) < 3) begin
        e = $urandom_range(ENTRIES - 1);
        if ($urandom_range(1))
          write_table(e, $urandom_range(127, NAME_BYTES), 8'($urandom));
        else
          send_beat(REQ_IGNORED, 8'($urandom), 1'($urandom_range(1)),
                    4'($urandom), 7'($urandom));
      end
      send_beat(REQ_PKT_BYTE, pkt[i], i == pkt.size() - 1, 4'($urandom),
                7'($urandom));
    end
    n_pkts++;
  endtask

  task random_packet();
    bytes_t nm, pkt;
    int kind, e, k;
    kind = $urandom_range(99);
    e = $urandom_range(ENTRIES - 1);
    if (kind < 55 && entry_names[e].size() > 0) begin
      nm = entry_names[e];
    end else if (kind < 70) begin
      nm = make_name($urandom_range(3), 8);
    end else if (kind < 80) begin
      // long labels can push the name past its limit
      nm = make_name($urandom_range(3, 2), LABEL_MAX);
    end else begin
      nm = make_name($urandom_range(3, 1), 6);
      if (kind < 90) begin
        // corrupt one label length
        nm[0] = 8'($urandom_range(255, LABEL_MAX + 1));
      end
    end
    pkt = make_packet(nm, ($urandom_range(3) == 0) ? $urandom_range(9) : 0);
    if (kind >= 90) begin
      // truncate at a random point
      k = $urandom_range(pkt.size() - 1, 1);
      while (pkt.size() > k) void'(pkt.pop_back());
    end
    send_packet(pkt);
  endtask

  initial begin
    bytes_t nm, pkt;
    int e;
    foreach (written[i]) written[i] = '0;
    in_if.valid        <= 1'b0;
    in_if.req_type     <= REQ_PKT_BYTE;
    in_if.data_byte    <= 8'h00;
    in_if.packet_end   <= 1'b0;
    in_if.entry_index  <= 4'd0;
    in_if.entry_offset <= 7'd0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // Miss with an empty table, a truncation inside the header and one at its end.
    send_packet(make_packet(make_name(0, 1), 0));
    pkt = make_packet(make_name(1, 3), 0);
    pkt = pkt[0:0];
    send_packet(pkt);
    pkt = make_packet(make_name(1, 3), 0);
    pkt = pkt[0:HDR_LEN - 1];
    send_packet(pkt);

    // Table: random names, the root name, a name of the maximum length, a
    // duplicate of entry 2 at entry 8 (lowest entry must win), and entry 15.
    for (int i = 0; i < 4; i++) load_entry(i, make_name($urandom_range(3, 1), 6));
    load_entry(6, make_name(0, 1));
    nm = {8'(NAME_BYTES - 2)};
    repeat (NAME_BYTES - 2) nm = {nm, 8'($urandom)};
    nm = {nm, 8'h00};
    load_entry(7, nm);
    load_entry(8, entry_names[2]);
    load_entry(15, make_name(2, 5));
    foreach (entry_names[i]) if (entry_names[i].size() > 0) set_valid(i, 1'b1);
    set_valid(12, 1'b1);  // unloaded entries stay invalid

    // Root name hit, longest name hit, duplicate, label length of 64,
    // a 63-byte label that overflows the name.
    send_packet(make_packet(entry_names[6], 0));
    send_packet(make_packet(entry_names[7], 0));
    send_packet(make_packet(entry_names[2], 2));
    nm = make_name(1, 3);
    nm[0] = 8'(LABEL_MAX + 1);
    send_packet(make_packet(nm, 0));
    nm = {8'(LABEL_MAX)};
    repeat (LABEL_MAX) nm = {nm, 8'($urandom)};
    nm = {nm, 8'h00};
    send_packet(make_packet(nm, 0));

    // Random part.
    while (n_sent < ITEMS) begin
      if ($urandom_range(3) == 0) begin
        e = $urandom_range(ENTRIES - 1);
        case ($urandom_range(2))
          0: set_valid(e, $urandom_range(3) != 0);
          1: load_entry(e, make_name($urandom_range(3), 7));
          default: write_table(e, $urandom_range(127, NAME_BYTES), 8'($urandom));
        endcase
      end
      random_packet();
    end
    idle_on = 1'b1;

    in_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (sb.owed_q.size() != 0) sb.report("response beats never arrived");
    $display("covered %0d packets in %0d input beats: %0d hits, %0d misses, %0d malformed",
             n_pkts, n_sent, sb.n_hit, sb.n_miss, sb.n_bad);
    $display("checked %0d response beats, %0d mismatches", sb.n_beats, sb.errors);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
